@@ hdl/cfrf_pkg.sv @@
// ---------------------------------------------------------------------------
// cfrf_pkg
// Shared types, codes and the default tap table of the complex FIR core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfrf_pkg;

   // item kind carried on the request channel
   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_TAP    = 1'b1
   } op_type;

   // back-end sequencer
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MAC,
      BK_WAIT
   } back_state_type;

   localparam int QUEUE_DEPTH = 2;
   localparam int DEFAULT_TAP_COUNT = 45;
   localparam logic [6:0] TAP_COUNT_RESET = 7'd45;

   // classified job handed from the front to the back
   typedef struct packed {
      op_type             op;
      logic signed [15:0] sample_re;
      logic signed [15:0] sample_im;
      logic [5:0]         tap_index;
      logic signed [17:0] tap_value;
      logic               has_out;   // sample produces at least one result
      logic               sweep;     // frame end: count window span down to zero
      logic [5:0]         d_start;   // window span of the first result
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // quantized 45-tap low-pass, Q2.16
   localparam logic signed [17:0] DEFAULT_TAPS [DEFAULT_TAP_COUNT] = '{
      -18'sd72,    18'sd79,    -18'sd55,   -18'sd12,   18'sd121,   -18'sd233,
      18'sd275,    -18'sd167,  -18'sd120,  18'sd512,   -18'sd825,  18'sd827,
      -18'sd352,   -18'sd568,  18'sd1637,  -18'sd2337, 18'sd2095,  -18'sd521,
      -18'sd2385,  18'sd6147,  -18'sd9908, 18'sd12686, 18'sd51890,
      18'sd12686,  -18'sd9908, 18'sd6147,  -18'sd2385, -18'sd521,  18'sd2095,
      -18'sd2337,  18'sd1637,  -18'sd568,  -18'sd352,  18'sd827,   -18'sd825,
      18'sd512,    -18'sd120,  -18'sd167,  18'sd275,   -18'sd233,  18'sd121,
      -18'sd12,    -18'sd55,   18'sd79,    -18'sd72
   };

   function automatic logic signed [17:0] default_tap(input logic [5:0] idx);
      if (idx < 6'(DEFAULT_TAP_COUNT)) begin
         return DEFAULT_TAPS[idx];
      end
      return 18'sd0;
   endfunction

endpackage

`default_nettype wire

@@ hdl/cfrf_req_if.sv @@
// ---------------------------------------------------------------------------
// cfrf_req_if
// Request channel: sample beats and tap write beats.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cfrf_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic signed [15:0] sample_re;
   logic signed [15:0] sample_im;
   logic               frame_last;
   logic [5:0]         tap_index;
   logic signed [17:0] tap_value;

   modport source (
      output valid, operation, sample_re, sample_im, frame_last, tap_index, tap_value,
      input  ready
   );
   modport sink (
      input  valid, operation, sample_re, sample_im, frame_last, tap_index, tap_value,
      output ready
   );
endinterface

`default_nettype wire

@@ hdl/cfrf_rsp_if.sv @@
// ---------------------------------------------------------------------------
// cfrf_rsp_if
// Response channel: filtered complex output beats.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cfrf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_re;
   logic signed [15:0] out_im;
   logic               run_last;
   logic               frame_end;

   modport source (
      output valid, out_re, out_im, run_last, frame_end,
      input  ready
   );
   modport sink (
      input  valid, out_re, out_im, run_last, frame_end,
      output ready
   );
endinterface

`default_nettype wire

@@ hdl/cfrf_ram.sv @@
// ---------------------------------------------------------------------------
// cfrf_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfrf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ hdl/cfrf_front.sv @@
// ---------------------------------------------------------------------------
// cfrf_front
// Accepts request beats, tracks the frame position and turns each beat
// into a job: tap write, or sample with the window span of its results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfrf_front #(
   parameter int MAX_TAPS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   cfrf_req_if.sink                  req,
   input  wire logic [6:0]           tap_count,
   input  wire cfrf_pkg::q_stat_type q_stat,
   output logic                      q_push,
   output cfrf_pkg::cmd_type         q_cmd
);

   localparam int CW = $clog2(MAX_TAPS + 1);

   logic [CW-1:0] pos_ff, pos_in;
   logic [6:0]    taps7, count7, span7;
   logic          is_sample;

   assign req.ready = !q_stat.full;
   assign q_push    = req.valid && req.ready;
   assign is_sample = (cfrf_pkg::op_type'(req.operation) == cfrf_pkg::OP_SAMPLE);

   always_comb begin
      // taps in use, clamped to 1..MAX_TAPS
      if (tap_count == 7'd0) begin
         taps7 = 7'd1;
      end else if (tap_count > 7'(MAX_TAPS)) begin
         taps7 = 7'(MAX_TAPS);
      end else begin
         taps7 = tap_count;
      end
      // samples in frame including this one, saturating
      if (7'(pos_ff) >= 7'(MAX_TAPS)) begin
         count7 = 7'(MAX_TAPS);
      end else begin
         count7 = 7'(pos_ff) + 7'd1;
      end
      if (req.frame_last) begin
         span7 = ((count7 < taps7) ? count7 : taps7) - 7'd1;
      end else begin
         span7 = taps7 - 7'd1;
      end
   end

   always_comb begin
      q_cmd.op        = cfrf_pkg::op_type'(req.operation);
      q_cmd.sample_re = req.sample_re;
      q_cmd.sample_im = req.sample_im;
      q_cmd.tap_index = req.tap_index;
      q_cmd.tap_value = req.tap_value;
      q_cmd.sweep     = is_sample && req.frame_last;
      q_cmd.has_out   = is_sample && (req.frame_last || (count7 >= taps7));
      q_cmd.d_start   = 6'(span7);
   end

   always_comb begin
      pos_in = pos_ff;
      if (q_push && is_sample) begin
         pos_in = req.frame_last ? '0 : CW'(count7);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/cfrf_cmd_queue.sv @@
// ---------------------------------------------------------------------------
// cfrf_cmd_queue
// Two-entry job queue between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfrf_cmd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire cfrf_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output cfrf_pkg::cmd_type      head,
   output cfrf_pkg::q_stat_type   q_stat
);

   cfrf_pkg::cmd_type entry_ff [cfrf_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign q_stat.full  = (cnt_ff == 2'(cfrf_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (cnt_ff == 2'd0);
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/cfrf_back.sv @@
// ---------------------------------------------------------------------------
// cfrf_back
// Executes jobs: tap writes, history writes and the shared I/Q
// multiply-accumulate, then rounds, saturates and drives the response.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfrf_back #(
   parameter int MAX_TAPS     = 64,
   parameter int SAMPLE_WIDTH = 16,
   parameter int TAP_WIDTH    = 18
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cfrf_pkg::q_stat_type q_stat,
   input  wire cfrf_pkg::cmd_type    head,
   output logic                      q_pop,
   cfrf_rsp_if.source                rsp
);

   // stored sample / tap widths; results saturate to the sample width
   localparam int SW     = (SAMPLE_WIDTH < 16) ? SAMPLE_WIDTH : 16;
   localparam int TW     = (TAP_WIDTH < 18) ? TAP_WIDTH : 18;
   localparam int HAW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int HDEPTH = 2 ** HAW;
   localparam int CW     = $clog2(MAX_TAPS + 1);
   localparam int PW     = SW + TW;
   localparam int AW     = PW + CW;

   localparam logic signed [AW-1:0] RND    = AW'(2 ** 15);
   localparam logic signed [AW-1:0] SAT_HI = AW'(2 ** (SW - 1) - 1);
   localparam logic signed [AW-1:0] SAT_LO = AW'(-(2 ** (SW - 1)));

   cfrf_pkg::back_state_type state_ff, state_in;

   logic [HAW-1:0]      newest_ff, newest_in;
   logic [HAW-1:0]      d_ff, d_in;
   logic [HAW-1:0]      j_ff, j_in;
   logic                sweep_ff, sweep_in;
   logic [MAX_TAPS-1:0] tap_valid_ff, tap_valid_in;

   logic                 s1_vld_ff, s1_vld_in;
   logic                 s1_first_ff, s1_first_in;
   logic                 s1_last_ff, s1_last_in;
   logic                 s1_tval_ff, s1_tval_in;
   logic signed [TW-1:0] s1_tdef_ff, s1_tdef_in;

   logic                 s2_vld_ff, s2_vld_in;
   logic                 s2_first_ff, s2_first_in;
   logic                 s2_last_ff, s2_last_in;
   logic signed [PW-1:0] prod_re_ff, prod_re_in;
   logic signed [PW-1:0] prod_im_ff, prod_im_in;

   logic signed [AW-1:0] acc_re_ff, acc_re_in;
   logic signed [AW-1:0] acc_im_ff, acc_im_in;
   logic                 acc_done_ff, acc_done_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]   out_re_ff, out_re_in;
   logic signed [15:0]   out_im_ff, out_im_in;
   logic                 run_last_ff, run_last_in;
   logic                 frame_end_ff, frame_end_in;

   logic                 pop_tap, pop_sample, tap_we, issue, load_out, more_out;
   logic [HAW-1:0]       tap_waddr, hist_waddr, hist_raddr;
   logic [TW-1:0]        tap_rdata;
   logic [2*SW-1:0]      hist_rdata;
   logic signed [17:0]   def_full;
   logic signed [TW-1:0] tap_val;
   logic signed [SW-1:0] hist_re, hist_im;
   logic signed [AW-1:0] sh_re, sh_im, sat_re, sat_im;

   // ---------------- sequencer ----------------
   assign load_out = (state_ff == cfrf_pkg::BK_WAIT) && acc_done_ff &&
                     (!rsp_valid_ff || rsp.ready);
   assign more_out = sweep_ff && (d_ff != '0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cfrf_pkg::BK_IDLE: begin
            if (!q_stat.empty && (head.op == cfrf_pkg::OP_SAMPLE) && head.has_out) begin
               state_in = cfrf_pkg::BK_MAC;
            end
         end
         cfrf_pkg::BK_MAC: begin
            if (j_ff == d_ff) begin
               state_in = cfrf_pkg::BK_WAIT;
            end
         end
         cfrf_pkg::BK_WAIT: begin
            if (load_out) begin
               state_in = more_out ? cfrf_pkg::BK_MAC : cfrf_pkg::BK_IDLE;
            end
         end
         default: state_in = cfrf_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop = 1'b0;
      issue = 1'b0;
      unique case (state_ff)
         cfrf_pkg::BK_IDLE: q_pop = !q_stat.empty;
         cfrf_pkg::BK_MAC:  issue = 1'b1;
         cfrf_pkg::BK_WAIT: ;
         default: ;
      endcase
   end

   assign pop_tap    = q_pop && (head.op == cfrf_pkg::OP_TAP);
   assign pop_sample = q_pop && (head.op == cfrf_pkg::OP_SAMPLE);
   assign tap_we     = pop_tap && (7'(head.tap_index) < 7'(MAX_TAPS));
   assign tap_waddr  = head.tap_index[HAW-1:0];
   assign hist_waddr = newest_ff + HAW'(1);
   // sample d - j back from the newest one
   assign hist_raddr = newest_ff - (d_ff - j_ff);

   always_comb begin
      newest_in    = pop_sample ? hist_waddr : newest_ff;
      tap_valid_in = tap_valid_ff;
      if (tap_we) begin
         tap_valid_in[tap_waddr] = 1'b1;
      end
      d_in     = d_ff;
      j_in     = j_ff;
      sweep_in = sweep_ff;
      if (pop_sample) begin
         d_in     = head.d_start[HAW-1:0];
         j_in     = '0;
         sweep_in = head.sweep;
      end else if (issue && (j_ff != d_ff)) begin
         j_in = j_ff + HAW'(1);
      end else if (load_out && more_out) begin
         d_in = d_ff - HAW'(1);
         j_in = '0;
      end
   end

   // ---------------- memories ----------------
   cfrf_ram #(.WIDTH(TW), .DEPTH(MAX_TAPS)) u_tap_ram (
      .clock (clock),
      .we    (tap_we),
      .waddr (tap_waddr),
      .wdata (head.tap_value[TW-1:0]),
      .raddr (j_ff),
      .rdata (tap_rdata)
   );

   cfrf_ram #(.WIDTH(2 * SW), .DEPTH(HDEPTH)) u_hist_ram (
      .clock (clock),
      .we    (pop_sample),
      .waddr (hist_waddr),
      .wdata ({head.sample_im[SW-1:0], head.sample_re[SW-1:0]}),
      .raddr (hist_raddr),
      .rdata (hist_rdata)
   );

   // ---------------- MAC pipeline ----------------
   assign def_full    = cfrf_pkg::default_tap(6'(j_ff));
   assign s1_vld_in   = issue;
   assign s1_first_in = (j_ff == '0);
   assign s1_last_in  = (j_ff == d_ff);
   assign s1_tval_in  = tap_valid_ff[j_ff];
   assign s1_tdef_in  = def_full[TW-1:0];

   assign tap_val     = s1_tval_ff ? signed'(tap_rdata) : s1_tdef_ff;
   assign hist_re     = signed'(hist_rdata[SW-1:0]);
   assign hist_im     = signed'(hist_rdata[2*SW-1:SW]);
   assign prod_re_in  = PW'(tap_val) * PW'(hist_re);
   assign prod_im_in  = PW'(tap_val) * PW'(hist_im);
   assign s2_vld_in   = s1_vld_ff;
   assign s2_first_in = s1_first_ff;
   assign s2_last_in  = s1_last_ff;

   always_comb begin
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (s2_vld_ff) begin
         acc_re_in = (s2_first_ff ? AW'(0) : acc_re_ff) + AW'(prod_re_ff);
         acc_im_in = (s2_first_ff ? AW'(0) : acc_im_ff) + AW'(prod_im_ff);
      end
      acc_done_in = acc_done_ff;
      if (load_out) begin
         acc_done_in = 1'b0;
      end else if (s2_vld_ff && s2_last_ff) begin
         acc_done_in = 1'b1;
      end
   end

   // ---------------- round, saturate, output register ----------------
   always_comb begin
      sh_re  = (acc_re_ff + RND) >>> 16;
      sh_im  = (acc_im_ff + RND) >>> 16;
      sat_re = (sh_re > SAT_HI) ? SAT_HI : ((sh_re < SAT_LO) ? SAT_LO : sh_re);
      sat_im = (sh_im > SAT_HI) ? SAT_HI : ((sh_im < SAT_LO) ? SAT_LO : sh_im);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      out_re_in    = out_re_ff;
      out_im_in    = out_im_ff;
      run_last_in  = run_last_ff;
      frame_end_in = frame_end_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         out_re_in    = 16'(sat_re);
         out_im_in    = 16'(sat_im);
         run_last_in  = !more_out;
         frame_end_in = sweep_ff && (d_ff == '0);
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_re    = out_re_ff;
   assign rsp.out_im    = out_im_ff;
   assign rsp.run_last  = run_last_ff;
   assign rsp.frame_end = frame_end_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cfrf_pkg::BK_IDLE;
         newest_ff    <= '0;
         tap_valid_ff <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         acc_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         newest_ff    <= newest_in;
         tap_valid_ff <= tap_valid_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         acc_done_ff  <= acc_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff         <= d_in;
      j_ff         <= j_in;
      sweep_ff     <= sweep_in;
      s1_first_ff  <= s1_first_in;
      s1_last_ff   <= s1_last_in;
      s1_tval_ff   <= s1_tval_in;
      s1_tdef_ff   <= s1_tdef_in;
      s2_first_ff  <= s2_first_in;
      s2_last_ff   <= s2_last_in;
      prod_re_ff   <= prod_re_in;
      prod_im_ff   <= prod_im_in;
      acc_re_ff    <= acc_re_in;
      acc_im_ff    <= acc_im_in;
      out_re_ff    <= out_re_in;
      out_im_ff    <= out_im_in;
      run_last_ff  <= run_last_in;
      frame_end_ff <= frame_end_in;
   end

endmodule

`default_nettype wire

@@ hdl/complex_fir_real_taps_frame_core.sv @@
// ---------------------------------------------------------------------------
// complex_fir_real_taps_frame_core
// Frame-based complex FIR with real taps: I and Q are filtered with one
// shared tap set, truncated at frame end, rounded and saturated.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake              beat carries
//  --------  ---  ---------------------  ----------------------------------
//  req_bus   in   valid/ready            sample or tap write
//  rsp_bus   out  valid/ready            filtered I/Q, run_last, frame_end
//  csr_*     in   csr_wr_en (no stall)   tap_count
//
//  Sequence: the back pops a job, then a result with window span d runs
//  the shared I/Q multiply-accumulate over taps 0..d and passes the RAM
//  read, product register, accumulator and result load; a frame end flush
//  does this for each of its results in turn, and a tap write is done
//  when the back pops it.
//  Reset: synchronous; taps read as the default low-pass through per-entry
//  valid bits, so no clearing pass is needed.
//  Stalls: a two-beat job queue decouples req_bus from the MAC, and the
//  response register lets the MAC finish the next sum while a beat waits.
//
`timescale 1ns / 1ps
`default_nettype none

module complex_fir_real_taps_frame_core #(
   parameter int MAX_TAPS     = 64,
   parameter int SAMPLE_WIDTH = 16,
   parameter int TAP_WIDTH    = 18
) (
   input  wire logic       clock,
   input  wire logic       reset,
   cfrf_req_if.sink        req_bus,
   cfrf_rsp_if.source      rsp_bus,
   input  wire logic       csr_wr_en,
   input  wire logic [6:0] csr_wr_data
);

   // tap count register; the user must write it only while the core is idle (not enforced here)
   logic [6:0] tap_count_ff, tap_count_in;

   logic                 q_push, q_pop;
   cfrf_pkg::cmd_type    q_cmd, q_head;
   cfrf_pkg::q_stat_type q_stat;

   assign tap_count_in = csr_wr_en ? csr_wr_data : tap_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= cfrf_pkg::TAP_COUNT_RESET;
      end else begin
         tap_count_ff <= tap_count_in;
      end
   end

   // front: accept beats, track frame position, classify
   cfrf_front #(.MAX_TAPS(MAX_TAPS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .tap_count (tap_count_ff),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   // job queue between front and back
   cfrf_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .q_stat   (q_stat)
   );

   // back: memories, MAC, rounding and response register
   cfrf_back #(
      .MAX_TAPS     (MAX_TAPS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .TAP_WIDTH    (TAP_WIDTH)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .q_stat (q_stat),
      .head   (q_head),
      .q_pop  (q_pop),
      .rsp    (rsp_bus)
   );

   // ---------------- assertions ----------------
   // the frame's final result always closes its run
   a_frame_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.frame_end) |-> rsp_bus.run_last)
      else $error("frame_end beat without run_last");

   // back never pops an empty queue
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("job queue popped while empty");

   // a csr write lands in the tap count register
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (tap_count_ff == $past(csr_wr_data)))
      else $error("tap_count write lost");

endmodule

`default_nettype wire

@@ tb/complex_fir_real_taps_frame_core_test.sv @@
// ---------------------------------------------------------------------------
// complex_fir_real_taps_frame_core_test
// Self-checking bench for the frame FIR core. Sample and tap write beats go
// in with random gaps and response stalls. A cycle-free model of the filter
// predicts every output beat, and each beat that comes back is compared
// field by field. The tap count is changed between phases while the core
// is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module complex_fir_real_taps_frame_core_test;

   localparam int TAP_SLOTS     = 64;
   localparam int SETTLE_CYCLES = 120;    // > one full 64-tap result plus queue
   localparam int PHASE_ITEMS   = 30;

   // power-on low-pass in Q2.16, kept here apart from the RTL's copy
   localparam int LOWPASS_LEN = 45;
   localparam logic signed [17:0] LOWPASS [LOWPASS_LEN] = '{
      -18'sd72,    18'sd79,    -18'sd55,   -18'sd12,   18'sd121,   -18'sd233,
      18'sd275,    -18'sd167,  -18'sd120,  18'sd512,   -18'sd825,  18'sd827,
      -18'sd352,   -18'sd568,  18'sd1637,  -18'sd2337, 18'sd2095,  -18'sd521,
      -18'sd2385,  18'sd6147,  -18'sd9908, 18'sd12686, 18'sd51890,
      18'sd12686,  -18'sd9908, 18'sd6147,  -18'sd2385, -18'sd521,  18'sd2095,
      -18'sd2337,  18'sd1637,  -18'sd568,  -18'sd352,  18'sd827,   -18'sd825,
      18'sd512,    -18'sd120,  -18'sd167,  18'sd275,   -18'sd233,  18'sd121,
      -18'sd12,    -18'sd55,   18'sd79,    -18'sd72
   };

   typedef struct {
      cfrf_pkg::op_type   op;
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic               last;
      logic [5:0]         index;
      logic signed [17:0] coeff;
   } req_beat_type;

   typedef struct {
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic               run_last;
      logic               frame_end;
   } rsp_beat_type;

   // -------------------------------------------------------------------------
   // Filter model plus the queue of outputs still owed by the core.
   // -------------------------------------------------------------------------
   class filtered_output_board;
      logic signed [15:0] hist_re [TAP_SLOTS];   // newest sample at 0
      logic signed [15:0] hist_im [TAP_SLOTS];
      logic signed [17:0] coeffs  [TAP_SLOTS];
      int                 frame_fill;            // saturates at TAP_SLOTS
      logic [6:0]         tap_count;
      rsp_beat_type       awaited [$];
      int                 fails;

      function new();
         for (int i = 0; i < TAP_SLOTS; i++) begin
            hist_re[i] = '0;
            hist_im[i] = '0;
            coeffs[i]  = (i < LOWPASS_LEN) ? LOWPASS[i] : 18'sd0;
         end
         frame_fill = 0;
         tap_count  = cfrf_pkg::TAP_COUNT_RESET;
         fails      = 0;
      endfunction

      // zero acts as one, anything past the memory acts as the full memory
      function int taps_active();
         if (tap_count == 0) return 1;
         if (tap_count > TAP_SLOTS) return TAP_SLOTS;
         return int'(tap_count);
      endfunction

      function logic signed [15:0] round_sat(longint acc);
         longint r;
         r = (acc + 64'sd32768) >>> 16;   // round half up, floor shift
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         return 16'(r);
      endfunction

      // output whose window ends span samples before the newest one
      function void window_sum(int span, int taps, bit run_last, bit fend);
         longint       acc_re;
         longint       acc_im;
         rsp_beat_type o;
         acc_re = 0;
         acc_im = 0;
         for (int j = 0; j < taps && j <= span; j++) begin
            acc_re += longint'(coeffs[j]) * longint'(hist_re[span - j]);
            acc_im += longint'(coeffs[j]) * longint'(hist_im[span - j]);
         end
         o.re        = round_sat(acc_re);
         o.im        = round_sat(acc_im);
         o.run_last  = run_last;
         o.frame_end = fend;
         awaited.push_back(o);
      endfunction

      function void note_beat(req_beat_type b);
         int taps;
         int top;
         if (b.op == cfrf_pkg::OP_TAP) begin
            coeffs[b.index] = b.coeff;
            return;
         end
         for (int i = TAP_SLOTS - 1; i > 0; i--) begin
            hist_re[i] = hist_re[i - 1];
            hist_im[i] = hist_im[i - 1];
         end
         hist_re[0] = b.re;
         hist_im[0] = b.im;
         if (frame_fill < TAP_SLOTS) frame_fill++;
         taps = taps_active();
         if (!b.last) begin
            if (frame_fill >= taps) window_sum(taps - 1, taps, 1'b1, 1'b0);
            return;
         end
         // frame end: flush every remaining output, oldest window first
         top = ((frame_fill < taps) ? frame_fill : taps) - 1;
         for (int d = top; d >= 0; d--) window_sum(d, taps, d == 0, d == 0);
         frame_fill = 0;
      endfunction

      function void check_beat(rsp_beat_type got);
         rsp_beat_type want;
         if (awaited.size() == 0) begin
            $error("output beat with none pending: out_re %0d out_im %0d",
                   got.re, got.im);
            fails++;
            return;
         end
         want = awaited.pop_front();
         if (got.re !== want.re) begin
            $error("out_re: expected %0d, got %0d", want.re, got.re);
            fails++;
         end
         if (got.im !== want.im) begin
            $error("out_im: expected %0d, got %0d", want.im, got.im);
            fails++;
         end
         if (got.run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
            fails++;
         end
         if (got.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
            fails++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and the core.
   // -------------------------------------------------------------------------
   logic       clock = 1'b0;
   logic       reset;
   logic       csr_wr_en;
   logic [6:0] csr_wr_data;
   bit         calm = 1'b0;        // final phase: no gaps, no stalls
   int         frame_pos_tb = 0;   // samples sent in the open frame
   int         frame_goal   = 1;   // length chosen for the open frame

   filtered_output_board board = new();

   cfrf_req_if req_bus ();
   cfrf_rsp_if rsp_bus ();

   always #6 clock = ~clock;

   complex_fir_real_taps_frame_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // hard stop in case the core hangs or owes beats forever
   initial begin
      #(100_000_000);
      $display("complex_fir_real_taps_frame_core verification failed");
      $finish;
   end

   // Response side: every accepted beat is checked at the rising edge, using
   // values that were settled since the previous falling edge.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         board.check_beat('{rsp_bus.out_re, rsp_bus.out_im,
                            rsp_bus.run_last, rsp_bus.frame_end});
      end
   end

   // Response backpressure: runs of ready broken by random stall bursts.
   // Once calm is set ready simply stays high.
   initial begin
      int run;
      rsp_bus.ready <= 1'b0;
      forever begin
         if (calm || $urandom_range(0, 2) != 0) begin
            run = $urandom_range(1, 30);
            repeat (run) begin
               @(negedge clock);
               rsp_bus.ready <= 1'b1;
            end
         end else begin
            run = $urandom_range(1, 18);
            repeat (run) begin
               @(negedge clock);
               rsp_bus.ready <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Beat builders. Fields a beat ignores still get random values so every
   // input bit toggles.
   // -------------------------------------------------------------------------
   function automatic req_beat_type sample_beat(logic signed [15:0] re,
                                                logic signed [15:0] im, logic last);
      req_beat_type b;
      b.op    = cfrf_pkg::OP_SAMPLE;
      b.re    = re;
      b.im    = im;
      b.last  = last;
      b.index = 6'($urandom);
      b.coeff = 18'($urandom);
      return b;
   endfunction

   function automatic req_beat_type tap_beat(logic [5:0] index,
                                             logic signed [17:0] coeff);
      req_beat_type b;
      b.op    = cfrf_pkg::OP_TAP;
      b.re    = 16'($urandom);
      b.im    = 16'($urandom);
      b.last  = 1'($urandom);
      b.index = index;
      b.coeff = coeff;
      return b;
   endfunction

   // mostly modest values so outputs stay in range, with extremes mixed in
   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 6))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2, 3:    return 16'($urandom);
         default: return 16'($urandom_range(0, 8000) - 4000);
      endcase
   endfunction

   function automatic logic signed [17:0] pick_coeff();
      case ($urandom_range(0, 7))
         0:       return 18'sh1ffff;
         1:       return 18'sh20000;
         2:       return 18'($urandom);
         default: return 18'($urandom_range(0, 24000) - 12000);
      endcase
   endfunction

   // frame lengths: at most the taps, at or just past them, or anything
   function automatic int pick_frame_len(int longest);
      int taps;
      taps = board.taps_active();
      case ($urandom_range(0, 2))
         0:       return $urandom_range(1, taps);
         1:       return $urandom_range(taps, taps + 12);
         default: return $urandom_range(1, longest);
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Drivers. Inputs move only at the falling edge, one assignment per edge.
   // -------------------------------------------------------------------------
   task automatic push_beat(req_beat_type b);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 18);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= b.op;
      req_bus.sample_re  <= b.re;
      req_bus.sample_im  <= b.im;
      req_bus.frame_last <= b.last;
      req_bus.tap_index  <= b.index;
      req_bus.tap_value  <= b.coeff;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      board.note_beat(b);
   endtask

   // drop valid, wait for every owed beat, then let a trailing job drain
   task automatic drain(int extra);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic set_tap_count(logic [6:0] value);
      drain(SETTLE_CYCLES);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      board.tap_count = value;
   endtask

   // random mix: about one beat in ten rewrites a tap, the rest are frames
   task automatic run_phase(int items, int longest);
      for (int n = 0; n < items; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            push_beat(tap_beat(6'($urandom), pick_coeff()));
         end else begin
            frame_pos_tb++;
            if (frame_pos_tb >= frame_goal) begin
               push_beat(sample_beat(pick_sample(), pick_sample(), 1'b1));
               frame_pos_tb = 0;
               frame_goal   = pick_frame_len(longest);
            end else begin
               push_beat(sample_beat(pick_sample(), pick_sample(), 1'b0));
            end
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      logic [6:0] phase_counts [7];
      req_bus.valid      <= 1'b0;
      req_bus.operation  <= cfrf_pkg::OP_SAMPLE;
      req_bus.sample_re  <= '0;
      req_bus.sample_im  <= '0;
      req_bus.frame_last <= 1'b0;
      req_bus.tap_index  <= '0;
      req_bus.tap_value  <= '0;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      reset              <= 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed, power-on taps (45) ---
      // one-sample frame: a single truncated output
      push_beat(sample_beat(16'sh7fff, 16'sh8000, 1'b1));
      // frame shorter than the taps: flush of three truncated sums
      push_beat(sample_beat(16'sh8000, 16'sh7fff, 1'b0));
      push_beat(sample_beat(16'sh0000, 16'sh0000, 1'b0));
      push_beat(sample_beat(16'sd12345, -16'sd12345, 1'b1));
      // tap extremes at both ends of the memory
      push_beat(tap_beat(6'd0, 18'sh1ffff));
      push_beat(tap_beat(6'd63, 18'sh20000));
      push_beat(tap_beat(6'd1, 18'sh1ffff));
      // saturation high on I, low on Q, then the other way round
      push_beat(sample_beat(16'sh7fff, 16'sh8000, 1'b0));
      push_beat(sample_beat(16'sh7fff, 16'sh8000, 1'b1));
      push_beat(sample_beat(16'sh8000, 16'sh7fff, 1'b1));
      push_beat(tap_beat(6'd1, 18'sh20000));
      push_beat(sample_beat(16'sd1, -16'sd1, 1'b0));
      push_beat(sample_beat(-16'sd1, 16'sd1, 1'b1));
      // half-unit products: rounding goes up on both signs
      push_beat(tap_beat(6'd0, 18'sd32768));
      push_beat(sample_beat(16'sd1, -16'sd1, 1'b1));
      push_beat(sample_beat(16'sd3, -16'sd3, 1'b1));

      // --- directed, single tap: every sample yields a beat ---
      set_tap_count(7'd1);
      push_beat(sample_beat(16'sd100, -16'sd100, 1'b0));
      push_beat(sample_beat(16'sd200, -16'sd200, 1'b0));
      push_beat(sample_beat(-16'sd5, 16'sd5, 1'b1));

      // --- random phases; 0 and 127 check the clamping of the count ---
      phase_counts = '{7'd64, 7'd0, 7'd127, 7'd2, 7'd45,
                       7'($urandom_range(3, 20)), 7'd1};
      frame_goal = pick_frame_len(80);
      for (int p = 0; p < 7; p++) begin
         set_tap_count(phase_counts[p]);
         frame_pos_tb = 0;
         frame_goal   = pick_frame_len(80);
         if (p == 6) calm = 1'b1;
         run_phase(PHASE_ITEMS, 80);
      end

      drain(2 * SETTLE_CYCLES);
      if (board.fails == 0) begin
         $display("complex_fir_real_taps_frame_core verification clean");
      end else begin
         $display("complex_fir_real_taps_frame_core verification failed");
      end
      $finish;
   end

endmodule
